// ----- rtl/tts_pkg.sv -----
// ----------------------------------------------------------------------------
// Task timer table scheduler: shared package
// Field widths, action and result codes, timer modes and the controller's
// state type.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int TTS_NUM_ENTRIES = 16;

    localparam int ACTION_W   = 2;
    localparam int SLOT_W     = 4;
    localparam int MODE_W     = 2;
    localparam int INTERVAL_W = 16;
    localparam int TIME_W     = 32;
    localparam int KIND_W     = 3;

    // A tick reports at most this many fired entries.
    localparam int MAX_FIRES  = 16;
    localparam int FIRE_CNT_W = $clog2(MAX_FIRES + 1);

    localparam int HOURS_PER_DAY = 24;
    localparam int SECS_PER_MIN  = 60;
    localparam int SECS_PER_DAY  = HOURS_PER_DAY * 3600;

    // Widest period: the largest interval in minutes, in seconds.
    localparam int PERIOD_W = 22;
    localparam int DIV_STEPS = TIME_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK   = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_TOGGLE = 2'd3
    } action_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_FIRED     = 3'd0,
        KIND_ADDED     = 3'd1,
        KIND_DELETED   = 3'd2,
        KIND_TOGGLED   = 3'd3,
        KIND_NOT_FOUND = 3'd4,
        KIND_FULL      = 3'd5
    } kind_t;

    localparam logic [MODE_W-1:0] MODE_ONCE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DAILY    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INTERVAL = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [INTERVAL_W-1:0] interval;
        logic [TIME_W-1:0]     next_run;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDIT,
        ST_ADD,
        ST_SCAN,
        ST_CHECK,
        ST_DIV,
        ST_WRITE,
        ST_FIRE,
        ST_EMIT
    } state_t;

endpackage

// ----- rtl/task_timer_table_scheduler.sv -----
// ----------------------------------------------------------------------------
// Task timer table scheduler
// A table of one-shot, daily and interval timers kept in a single-port
// synchronous memory, with add, delete, toggle and tick commands.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Beat contents
//  --------+-----------+--------------------+---------------------------------
//  s_      | in        | s_valid / s_ready  | action, slot, mode, interval,
//          |           |                    | time value
//  m_      | out       | m_valid / m_ready  | kind, slot id, active mark, last
//
// Add, delete and toggle produce one beat; an add searches past each occupied
// slot in turn for the first free one. A tick walks the table one entry a
// cycle while entries are empty or inactive; a valid active entry is read
// from memory, and a due daily or interval entry then passes the 32-step
// bit-serial remainder unit and the write-back before it is reported.
// Mode, interval and next-run time need no clearing after reset; the valid and
// active marks are flip-flops cleared at once.
// The output register lets a new command be taken while a beat waits; a
// stalled output holds back only the next beat that the controller produces.
//
module task_timer_table_scheduler
    import tts_pkg::*;
#(
    parameter int NUM_ENTRIES = TTS_NUM_ENTRIES
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ACTION_W-1:0]   s_action,
    input  logic [SLOT_W-1:0]     s_slot,
    input  logic [MODE_W-1:0]     s_mode,
    input  logic [INTERVAL_W-1:0] s_interval_minutes,
    input  logic [TIME_W-1:0]     s_time_value,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [KIND_W-1:0]     m_kind,
    output logic [SLOT_W-1:0]     m_slot_id,
    output logic                  m_now_active,
    output logic                  m_last
);

    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CNT_W = $clog2(NUM_ENTRIES + 1);

    // Entry storage
    entry_t entry_mem [NUM_ENTRIES];
    entry_t rd_data_reg;
    entry_t mem_wr_data;
    logic   mem_rd_en;
    logic   mem_wr_en;

    logic [NUM_ENTRIES-1:0] valid_reg, valid_next;
    logic [NUM_ENTRIES-1:0] active_reg, active_next;

    state_t state_reg, state_next;

    // Latched command
    action_t               action_reg, action_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic [INTERVAL_W-1:0] ivl_reg, ivl_next;
    logic [TIME_W-1:0]     tv_reg, tv_next;

    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      idx;
    logic [FIRE_CNT_W-1:0] fire_cnt_reg, fire_cnt_next;
    logic                  fire_act_reg, fire_act_next;

    // Remainder unit
    logic [TIME_W-1:0]    dvd_reg, dvd_next;
    logic [PERIOD_W-1:0]  rem_reg, rem_next;
    logic [PERIOD_W-1:0]  period_reg, period_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [PERIOD_W:0]    div_trial;

    // Result held back until it is known whether it is the last one
    logic                pend_valid_reg, pend_valid_next;
    kind_t               pend_kind_reg, pend_kind_next;
    logic [SLOT_W-1:0]   pend_slot_reg, pend_slot_next;
    logic                pend_act_reg, pend_act_next;

    logic                m_valid_reg, m_valid_next;
    kind_t               m_kind_reg, m_kind_next;
    logic [SLOT_W-1:0]   m_slot_reg, m_slot_next;
    logic                m_act_reg, m_act_next;
    logic                m_last_reg, m_last_next;

    logic                  out_free;
    logic                  slot_in_range;
    logic [IDX_W-1:0]      slot_idx;
    logic [INTERVAL_W-1:0] add_ivl;
    logic [PERIOD_W-1:0]   add_period;
    logic [TIME_W:0]       add_sum;
    logic [TIME_W-1:0]     add_first;
    logic [PERIOD_W-1:0]   entry_period;
    logic [TIME_W:0]       adv_sum;
    logic [TIME_W-1:0]     adv_next_run;
    logic                  entry_periodic;

    assign idx      = idx_reg[IDX_W-1:0];
    assign slot_idx = IDX_W'(slot_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign slot_in_range = (32'(slot_reg) < 32'(NUM_ENTRIES));

    // First run time of a new entry
    assign add_ivl    = ((mode_reg == MODE_INTERVAL) && (ivl_reg == '0))
                        ? INTERVAL_W'(1) : ivl_reg;
    assign add_period = PERIOD_W'(add_ivl) * PERIOD_W'(SECS_PER_MIN);
    assign add_sum    = {1'b0, tv_reg} + (TIME_W + 1)'(add_period);
    assign add_first  = (mode_reg != MODE_INTERVAL) ? tv_reg
                        : (add_sum[TIME_W] ? '1 : add_sum[TIME_W-1:0]);

    // Period of the entry just read
    assign entry_periodic = (rd_data_reg.mode == MODE_DAILY)
                         || (rd_data_reg.mode == MODE_INTERVAL);
    always_comb begin
        if (rd_data_reg.mode == MODE_DAILY) begin
            entry_period = PERIOD_W'(SECS_PER_DAY);
        end else if (rd_data_reg.interval == '0) begin
            entry_period = PERIOD_W'(SECS_PER_MIN);
        end else begin
            entry_period = PERIOD_W'(rd_data_reg.interval) * PERIOD_W'(SECS_PER_MIN);
        end
    end

    // Whole periods past now: now minus the remainder of the lag, plus one period.
    assign adv_sum      = {1'b0, tv_reg} - (TIME_W + 1)'(rem_reg)
                        + (TIME_W + 1)'(period_reg);
    assign adv_next_run = adv_sum[TIME_W] ? '1 : adv_sum[TIME_W-1:0];

    assign div_trial = {rem_reg, dvd_reg[TIME_W-1]};

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            entry_mem[idx] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            rd_data_reg <= entry_mem[idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            active_reg     <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            active_reg     <= active_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        action_reg    <= action_next;
        slot_reg      <= slot_next;
        mode_reg      <= mode_next;
        ivl_reg       <= ivl_next;
        tv_reg        <= tv_next;
        idx_reg       <= idx_next;
        fire_cnt_reg  <= fire_cnt_next;
        fire_act_reg  <= fire_act_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        period_reg    <= period_next;
        div_cnt_reg   <= div_cnt_next;
        pend_kind_reg <= pend_kind_next;
        pend_slot_reg <= pend_slot_next;
        pend_act_reg  <= pend_act_next;
        m_kind_reg    <= m_kind_next;
        m_slot_reg    <= m_slot_next;
        m_act_reg     <= m_act_next;
        m_last_reg    <= m_last_next;
    end

    always_comb begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        active_next     = active_reg;
        action_next     = action_reg;
        slot_next       = slot_reg;
        mode_next       = mode_reg;
        ivl_next        = ivl_reg;
        tv_next         = tv_reg;
        idx_next        = idx_reg;
        fire_cnt_next   = fire_cnt_reg;
        fire_act_next   = fire_act_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        period_next     = period_reg;
        div_cnt_next    = div_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_slot_next  = pend_slot_reg;
        pend_act_next   = pend_act_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_kind_next     = m_kind_reg;
        m_slot_next     = m_slot_reg;
        m_act_next      = m_act_reg;
        m_last_next     = m_last_reg;
        s_ready         = 1'b0;
        mem_rd_en       = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wr_data     = rd_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    action_next = action_t'(s_action);
                    slot_next   = s_slot;
                    mode_next   = s_mode;
                    ivl_next    = s_interval_minutes;
                    tv_next     = s_time_value;
                    idx_next    = '0;
                    unique case (action_t'(s_action))
                        ACT_TICK: begin
                            fire_cnt_next = '0;
                            state_next    = ST_SCAN;
                        end
                        ACT_ADD: begin
                            state_next = ST_ADD;
                        end
                        default: begin
                            state_next = ST_EDIT;
                        end
                    endcase
                end
            end

            ST_EDIT: begin
                pend_valid_next = 1'b1;
                pend_slot_next  = slot_reg;
                if (!slot_in_range || !valid_reg[slot_idx]) begin
                    pend_kind_next = KIND_NOT_FOUND;
                    pend_act_next  = 1'b0;
                end else if (action_reg == ACT_DELETE) begin
                    valid_next[slot_idx]  = 1'b0;
                    active_next[slot_idx] = 1'b0;
                    pend_kind_next        = KIND_DELETED;
                    pend_act_next         = 1'b0;
                end else begin
                    active_next[slot_idx] = !active_reg[slot_idx];
                    pend_kind_next        = KIND_TOGGLED;
                    pend_act_next         = !active_reg[slot_idx];
                end
                state_next = ST_EMIT;
            end

            ST_ADD: begin
                if (idx_reg == CNT_W'(NUM_ENTRIES)) begin
                    pend_valid_next = 1'b1;
                    pend_kind_next  = KIND_FULL;
                    pend_slot_next  = '0;
                    pend_act_next   = 1'b0;
                    state_next      = ST_EMIT;
                end else if (!valid_reg[idx]) begin
                    mem_wr_en            = 1'b1;
                    mem_wr_data.mode     = mode_reg;
                    mem_wr_data.interval = add_ivl;
                    mem_wr_data.next_run = add_first;
                    valid_next[idx]      = 1'b1;
                    active_next[idx]     = 1'b1;
                    pend_valid_next      = 1'b1;
                    pend_kind_next       = KIND_ADDED;
                    pend_slot_next       = SLOT_W'(idx);
                    pend_act_next        = 1'b1;
                    state_next           = ST_EMIT;
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            ST_SCAN: begin
                if ((idx_reg == CNT_W'(NUM_ENTRIES))
                        || (fire_cnt_reg == FIRE_CNT_W'(MAX_FIRES))) begin
                    state_next = pend_valid_reg ? ST_EMIT : ST_IDLE;
                end else if (valid_reg[idx] && active_reg[idx]) begin
                    mem_rd_en  = 1'b1;
                    state_next = ST_CHECK;
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            ST_CHECK: begin
                if (rd_data_reg.next_run <= tv_reg) begin
                    if (entry_periodic) begin
                        dvd_next     = tv_reg - rd_data_reg.next_run;
                        rem_next     = '0;
                        period_next  = entry_period;
                        div_cnt_next = '0;
                        state_next   = ST_DIV;
                    end else begin
                        active_next[idx] = 1'b0;
                        fire_act_next    = 1'b0;
                        state_next       = ST_FIRE;
                    end
                end else begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_SCAN;
                end
            end

            ST_DIV: begin
                // One restoring step: the trial fits in twice the period.
                if (div_trial >= {1'b0, period_reg}) begin
                    rem_next = PERIOD_W'(div_trial - {1'b0, period_reg});
                end else begin
                    rem_next = div_trial[PERIOD_W-1:0];
                end
                dvd_next     = {dvd_reg[TIME_W-2:0], 1'b0};
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_WRITE;
                end
            end

            ST_WRITE: begin
                mem_wr_en            = 1'b1;
                mem_wr_data.next_run = adv_next_run;
                fire_act_next        = 1'b1;
                state_next           = ST_FIRE;
            end

            ST_FIRE: begin
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_kind_next  = pend_kind_reg;
                        m_slot_next  = pend_slot_reg;
                        m_act_next   = pend_act_reg;
                        m_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_kind_next  = KIND_FIRED;
                    pend_slot_next  = SLOT_W'(idx);
                    pend_act_next   = fire_act_reg;
                    fire_cnt_next   = fire_cnt_reg + FIRE_CNT_W'(1);
                    idx_next        = idx_reg + CNT_W'(1);
                    state_next      = ST_SCAN;
                end
            end

            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_kind_next     = pend_kind_reg;
                    m_slot_next     = pend_slot_reg;
                    m_act_next      = pend_act_reg;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_slot_id    = m_slot_reg;
    assign m_now_active = m_act_reg;
    assign m_last       = m_last_reg;

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("held result left behind when returning to idle");

    a_fire_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIRE) |-> (fire_cnt_reg < FIRE_CNT_W'(MAX_FIRES)))
        else $error("tick reports more fired entries than allowed");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < period_reg))
        else $error("remainder unit out of range");

    a_advance_past_now: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE) |-> ((adv_next_run > tv_reg) || (adv_next_run == '1)))
        else $error("advanced next-run time not after current time");

    a_fire_from_live_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> valid_reg[idx])
        else $error("memory read issued for an empty entry");
`endif

endmodule

// ----- tb/task_timer_table_scheduler_test.sv -----
// ----------------------------------------------------------------------------
// Task timer table scheduler testbench
// Sends add, delete, toggle and tick commands and predicts result beats from
// a behavioural copy of the timer table or takes them from the directed rows.
// Result beats are checked in order, field by field, under several patterns
// of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module task_timer_table_scheduler_test;
    import tts_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 800;
    localparam int RANDOM_ITEMS = 244;
    localparam int NUM_PHASES   = 4;
    localparam int DIR_ROWS     = 15;
    localparam int MAX_REPORTS  = 10;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX   = '1;

    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot_id;
        logic              now_active;
        logic              last;
    } timer_result_t;

    typedef struct {
        action_t               action;
        logic [SLOT_W-1:0]     slot;
        logic [MODE_W-1:0]     mode;
        logic [INTERVAL_W-1:0] ivl;
        logic [TIME_W-1:0]     tv;
        int                    reps;
        bit                    typed;
        kind_t                 kind;
        logic [SLOT_W-1:0]     slot_id;
        logic                  now_active;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [ACTION_W-1:0]   s_action;
    logic [SLOT_W-1:0]     s_slot;
    logic [MODE_W-1:0]     s_mode;
    logic [INTERVAL_W-1:0] s_interval_minutes;
    logic [TIME_W-1:0]     s_time_value;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [KIND_W-1:0]     m_kind;
    logic [SLOT_W-1:0]     m_slot_id;
    logic                  m_now_active;
    logic                  m_last;

    task_timer_table_scheduler u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_slot             (s_slot),
        .s_mode             (s_mode),
        .s_interval_minutes (s_interval_minutes),
        .s_time_value       (s_time_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_slot_id          (m_slot_id),
        .m_now_active       (m_now_active),
        .m_last             (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the timer table.
    bit                    tmr_valid  [TTS_NUM_ENTRIES];
    bit                    tmr_active [TTS_NUM_ENTRIES];
    logic [MODE_W-1:0]     tmr_mode   [TTS_NUM_ENTRIES];
    logic [INTERVAL_W-1:0] tmr_ivl    [TTS_NUM_ENTRIES];
    logic [TIME_W-1:0]     tmr_next   [TTS_NUM_ENTRIES];

    timer_result_t step_results[$];
    timer_result_t pending_results[$];

    logic [TIME_W-1:0] clk_now;
    int send_idle_pct;
    int recv_stall_pct;
    int fail_count;
    int beats_sent;
    int beats_seen;
    int fires_seen;
    int unsigned cycle_count;

    int idle_plan  [NUM_PHASES] = '{0, 62, 0, 23};
    int stall_plan [NUM_PHASES] = '{0, 0, 62, 23};

    stim_row_t dir_rows [DIR_ROWS] = '{
        '{ACT_TICK,   4'd0,  MODE_ONCE,     16'd0,     32'd0,    1, 1'b0, KIND_FIRED,     4'd0,  1'b0},
        '{ACT_DELETE, 4'd0,  MODE_ONCE,     16'd0,     32'd0,    1, 1'b1, KIND_NOT_FOUND, 4'd0,  1'b0},
        '{ACT_TOGGLE, 4'd15, MODE_ONCE,     16'd0,     32'd0,    1, 1'b1, KIND_NOT_FOUND, 4'd15, 1'b0},
        '{ACT_ADD,    4'd0,  MODE_ONCE,     16'd0,     32'd100,  1, 1'b1, KIND_ADDED,     4'd0,  1'b1},
        '{ACT_ADD,    4'd0,  MODE_DAILY,    16'd0,     32'd50,   1, 1'b1, KIND_ADDED,     4'd1,  1'b1},
        '{ACT_ADD,    4'd0,  MODE_INTERVAL, 16'd0,     32'd0,    1, 1'b1, KIND_ADDED,     4'd2,  1'b1},
        '{ACT_ADD,    4'd0,  MODE_SPARE,    16'hFFFF,  32'd10,   1, 1'b1, KIND_ADDED,     4'd3,  1'b1},
        '{ACT_ADD,    4'd0,  MODE_INTERVAL, 16'hFFFF,  TIME_MAX, 1, 1'b1, KIND_ADDED,     4'd4,  1'b1},
        '{ACT_ADD,    4'd0,  MODE_DAILY,    16'd0,     32'd5,   11, 1'b1, KIND_ADDED,     4'd5,  1'b1},
        '{ACT_ADD,    4'd0,  MODE_ONCE,     16'd0,     32'd0,    1, 1'b1, KIND_FULL,      4'd0,  1'b0},
        '{ACT_TICK,   4'd0,  MODE_ONCE,     16'd0,     TIME_MAX, 1, 1'b0, KIND_FIRED,     4'd0,  1'b0},
        '{ACT_TICK,   4'd0,  MODE_ONCE,     16'd0,     TIME_MAX, 1, 1'b0, KIND_FIRED,     4'd0,  1'b0},
        '{ACT_TOGGLE, 4'd1,  MODE_ONCE,     16'd0,     32'd0,    1, 1'b1, KIND_TOGGLED,   4'd1,  1'b0},
        '{ACT_DELETE, 4'd2,  MODE_ONCE,     16'd0,     32'd0,    1, 1'b1, KIND_DELETED,   4'd2,  1'b0},
        '{ACT_DELETE, 4'd2,  MODE_ONCE,     16'd0,     32'd0,    1, 1'b1, KIND_NOT_FOUND, 4'd2,  1'b0}
    };

    function automatic logic [TIME_W-1:0] sat_time(logic [TIME_W-1:0] base,
                                                   logic [63:0] delta);
        logic [63:0] sum;
        sum = {32'd0, base} + delta;
        return (sum > {32'd0, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

    // Applies one command to the shadow table and leaves its result beats
    // in step_results.
    function automatic void timer_step(action_t action, logic [SLOT_W-1:0] slot,
                                       logic [MODE_W-1:0] mode,
                                       logic [INTERVAL_W-1:0] ivl,
                                       logic [TIME_W-1:0] tv);
        int i;
        int free_slot;
        logic [63:0] period;
        logic [63:0] steps;
        timer_result_t res;
        step_results.delete();
        case (action)
            ACT_TICK: begin
                for (i = 0; i < TTS_NUM_ENTRIES && step_results.size() < MAX_FIRES; i++) begin
                    if (tmr_valid[i] && tmr_active[i] && tmr_next[i] <= tv) begin
                        if (tmr_mode[i] == MODE_DAILY || tmr_mode[i] == MODE_INTERVAL) begin
                            if (tmr_mode[i] == MODE_DAILY)
                                period = 64'(SECS_PER_DAY);
                            else
                                period = 64'(tmr_ivl[i]) * 64'(SECS_PER_MIN);
                            // Whole periods until the run time lies after now.
                            steps = (64'(tv) - 64'(tmr_next[i])) / period + 64'd1;
                            tmr_next[i] = sat_time(tmr_next[i], steps * period);
                        end else begin
                            tmr_active[i] = 1'b0;
                        end
                        res = '{KIND_FIRED, SLOT_W'(i), tmr_active[i], 1'b0};
                        step_results = {step_results, res};
                    end
                end
            end
            ACT_ADD: begin
                free_slot = -1;
                for (i = TTS_NUM_ENTRIES - 1; i >= 0; i--)
                    if (!tmr_valid[i])
                        free_slot = i;
                if (free_slot < 0) begin
                    res = '{KIND_FULL, '0, 1'b0, 1'b0};
                end else begin
                    if (mode == MODE_INTERVAL && ivl == '0)
                        ivl = 16'd1;
                    tmr_valid[free_slot]  = 1'b1;
                    tmr_active[free_slot] = 1'b1;
                    tmr_mode[free_slot]   = mode;
                    tmr_ivl[free_slot]    = ivl;
                    tmr_next[free_slot]   = (mode == MODE_INTERVAL) ?
                        sat_time(tv, 64'(ivl) * 64'(SECS_PER_MIN)) : tv;
                    res = '{KIND_ADDED, SLOT_W'(free_slot), 1'b1, 1'b0};
                end
                step_results = {step_results, res};
            end
            default: begin
                if (!tmr_valid[slot]) begin
                    res = '{KIND_NOT_FOUND, slot, 1'b0, 1'b0};
                end else if (action == ACT_DELETE) begin
                    tmr_valid[slot]  = 1'b0;
                    tmr_active[slot] = 1'b0;
                    res = '{KIND_DELETED, slot, 1'b0, 1'b0};
                end else begin
                    tmr_active[slot] = !tmr_active[slot];
                    res = '{KIND_TOGGLED, slot, tmr_active[slot], 1'b0};
                end
                step_results = {step_results, res};
            end
        endcase
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat
    // has been taken.
    task automatic send_beat(input action_t action, input logic [SLOT_W-1:0] slot,
                             input logic [MODE_W-1:0] mode,
                             input logic [INTERVAL_W-1:0] ivl,
                             input logic [TIME_W-1:0] tv, input bit typed,
                             input timer_result_t typed_res);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid            = 1'b1;
        s_action           = action;
        s_slot             = slot;
        s_mode             = mode;
        s_interval_minutes = ivl;
        s_time_value       = tv;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        timer_step(action, slot, mode, ivl, tv);
        if (typed)
            pending_results = {pending_results, typed_res};
        else
            pending_results = {pending_results, step_results};
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic send_random_beat();
        int i;
        int pick;
        logic [SLOT_W-1:0] valid_slots[$];
        logic [SLOT_W-1:0] slot;
        logic [MODE_W-1:0] mode;
        logic [INTERVAL_W-1:0] ivl;
        logic [TIME_W-1:0] tv;
        action_t action;
        for (i = 0; i < TTS_NUM_ENTRIES; i++)
            if (tmr_valid[i])
                valid_slots = {valid_slots, SLOT_W'(i)};
        // Fields that the command does not use carry random noise.
        slot = SLOT_W'($urandom);
        mode = MODE_W'($urandom);
        ivl  = INTERVAL_W'($urandom);
        tv   = $urandom;
        pick = $urandom_range(99);
        if (valid_slots.size() < 4 && pick >= 40)
            pick = 50;
        if (pick < 40) begin
            action = ACT_TICK;
            case ($urandom_range(19))
                0:          clk_now = $urandom;
                1:          clk_now = TIME_MAX;
                2, 3, 4, 5: clk_now = sat_time(clk_now, 64'($urandom_range(200000)));
                default:    clk_now = sat_time(clk_now, 64'($urandom_range(3000)));
            endcase
            tv = clk_now;
        end else if (pick < 60) begin
            action = ACT_ADD;
            mode = ($urandom_range(9) == 0) ? MODE_SPARE : MODE_W'($urandom_range(2));
            case ($urandom_range(9))
                0:       ivl = '0;
                1, 2:    ivl = INTERVAL_W'($urandom);
                default: ivl = INTERVAL_W'($urandom_range(30, 1));
            endcase
            if (mode == MODE_INTERVAL)
                tv = clk_now;
            else
                tv = sat_time(clk_now, 64'($urandom_range(3600)));
            if ($urandom_range(9) == 0)
                tv = $urandom;
        end else begin
            action = ($urandom_range(1) == 0) ? ACT_DELETE : ACT_TOGGLE;
            if (valid_slots.size() > 0 && $urandom_range(9) != 0)
                slot = valid_slots[$urandom_range(valid_slots.size() - 1)];
        end
        send_beat(action, slot, mode, ivl, tv, 1'b0, '0);
    endtask

    task automatic note_failure(input string what, input timer_result_t want,
                                input timer_result_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s: expected kind %0d slot %0d active %0b last %0b,",
                     what, want.kind, want.slot_id, want.now_active, want.last,
                     " got kind %0d slot %0d active %0b last %0b",
                     got.kind, got.slot_id, got.now_active, got.last);
    endtask

    always @(negedge aclk)
        m_ready = ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        timer_result_t got;
        timer_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{kind_t'(m_kind), m_slot_id, m_now_active, m_last};
            beats_seen++;
            if (got.kind == KIND_FIRED)
                fires_seen++;
            if (pending_results.size() == 0) begin
                note_failure("Unexpected result beat", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want)
                    note_failure("Result mismatch", want, got);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out with %0d result beats outstanding", pending_results.size());
            $display("task_timer_table_scheduler_test NOT OK");
            $finish;
        end
    end

    initial begin
        stim_row_t row;
        timer_result_t typed_res;
        int r;
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_action           = ACT_TICK;
        s_slot             = '0;
        s_mode             = MODE_ONCE;
        s_interval_minutes = '0;
        s_time_value       = '0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        clk_now            = '0;
        for (int i = 0; i < TTS_NUM_ENTRIES; i++) begin
            tmr_valid[i]  = 1'b0;
            tmr_active[i] = 1'b0;
            tmr_mode[i]   = MODE_ONCE;
            tmr_ivl[i]    = '0;
            tmr_next[i]   = '0;
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        for (int k = 0; k < DIR_ROWS; k++) begin
            row = dir_rows[k];
            for (r = 0; r < row.reps; r++) begin
                typed_res = '{row.kind, row.slot_id + SLOT_W'(r), row.now_active, 1'b1};
                send_beat(row.action, row.slot, row.mode, row.ivl, row.tv, row.typed,
                          typed_res);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            // Hold off until the table has reported everything so far.
            s_valid = 1'b0;
            while (pending_results.size() != 0)
                @(negedge aclk);
            send_idle_pct  = idle_plan[p];
            recv_stall_pct = stall_plan[p];
            repeat (RANDOM_ITEMS / NUM_PHASES)
                send_random_beat();
        end

        s_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
        // A quiet tick may still be scanning the table.
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (pending_results.size() != 0) begin
            fail_count += pending_results.size();
            $display("%0d expected result beats never arrived", pending_results.size());
        end

        $display("Sent %0d command beats over %0d idling phases; checked %0d result beats,",
                 beats_sent, NUM_PHASES, beats_seen);
        $display("%0d of them timer firings, with %0d failures.", fires_seen, fail_count);
        if (fail_count == 0)
            $display("task_timer_table_scheduler_test OK");
        else
            $display("task_timer_table_scheduler_test NOT OK");
        $finish;
    end

endmodule
